// ===== hw/rtl/rtsf_pkg.sv =====
// shared types, constants and helpers of the resistive touch sample filter
// no dependencies; imported by every rtsf module
`default_nettype none

package rtsf_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned PressW    = 13;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // default depth of the queue between classifier and executor
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [SampleW-1:0]   FullScale      = 12'd4095;
  localparam logic [PressW-1:0]    ResetThreshold = 13'd400;
  localparam logic [IntervalW-1:0] ResetInterval  = 16'd3000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRotation  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInterval  = 2'd2;

  typedef enum logic [1:0] {
    RotSwapInvX = 2'd0,
    RotIdentity = 2'd1,
    RotSwapInvY = 2'd2,
    RotInvBoth  = 2'd3
  } rot_mode_e;

  typedef logic [SampleW-1:0] sample_t;

  // one classified sample set waiting for the executor
  typedef struct packed {
    logic    good;
    sample_t a0;
    sample_t a1;
    sample_t a2;
    sample_t b0;
    sample_t b1;
    sample_t b2;
  } qentry_t;

  function automatic sample_t abs_diff(sample_t a, sample_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // average of the closest pair; ties go to (p,q), then (p,r), then (q,r)
  function automatic sample_t closest_avg(sample_t p, sample_t q, sample_t r);
    sample_t            dpq;
    sample_t            dpr;
    sample_t            dqr;
    logic [SampleW:0]   sum;
    dpq = abs_diff(p, q);
    dpr = abs_diff(p, r);
    dqr = abs_diff(q, r);
    if (dpq <= dpr && dpq <= dqr) begin
      sum = {1'b0, p} + {1'b0, q};
    end else if (dpr <= dpq && dpr <= dqr) begin
      sum = {1'b0, p} + {1'b0, r};
    end else begin
      sum = {1'b0, q} + {1'b0, r};
    end
    return sum[SampleW:1];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtsf_front.sv =====
// front end: accepts sample sets, checks interval and pressure, keeps last good time
// depends on rtsf_pkg
`default_nettype none

module rtsf_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic [rtsf_pkg::TimeW-1:0]      now_us_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    pressure_one_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    pressure_two_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_a0_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_b0_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_a1_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_b1_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_a2_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_b2_i,
  input  wire logic [rtsf_pkg::PressW-1:0]     threshold_i,
  input  wire logic [rtsf_pkg::IntervalW-1:0]  interval_i,
  input  wire logic                            q_full_i,
  output logic                                 push_o,
  output rtsf_pkg::qentry_t                    entry_o
);
  import rtsf_pkg::*;

  logic [TimeW-1:0]  last_good_q;
  logic [TimeW-1:0]  last_good_d;
  logic [TimeW-1:0]  elapsed;
  logic [PressW-1:0] pressure;
  logic              time_ok;
  logic              press_ok;
  logic              good;

  // elapsed wraps modulo 2^32; pressure cannot go negative with 12-bit inputs
  assign elapsed  = now_us_i - last_good_q;
  assign time_ok  = elapsed >= {{(TimeW-IntervalW){1'b0}}, interval_i};
  assign pressure = {1'b0, pressure_one_i} + {1'b0, FullScale} - {1'b0, pressure_two_i};
  assign press_ok = pressure >= threshold_i;
  assign good     = time_ok && press_ok;

  assign push_o = in_valid_i && !q_full_i;

  assign entry_o.good = good;
  assign entry_o.a0   = sample_a0_i;
  assign entry_o.a1   = sample_a1_i;
  assign entry_o.a2   = sample_a2_i;
  assign entry_o.b0   = sample_b0_i;
  assign entry_o.b1   = sample_b1_i;
  assign entry_o.b2   = sample_b2_i;

  always_comb begin
    last_good_d = last_good_q;
    if (push_o && good) begin
      last_good_d = now_us_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_good_q <= '0;
    end else begin
      last_good_q <= last_good_d;
    end
  end

`ifndef SYNTHESIS
  a_time_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && good) |=> last_good_q == $past(now_us_i))
    else $error("last good time not taken from accepted good set");
  a_time_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && good) |=> $stable(last_good_q))
    else $error("last good time moved without a good set");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rtsf_queue.sv =====
// short fifo of classified sample sets between front end and executor
// depends on rtsf_pkg
`default_nettype none

module rtsf_queue #(
  parameter int unsigned Depth = rtsf_pkg::QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  rtsf_pkg::qentry_t       entry_i,
  input  wire logic               pop_i,
  output rtsf_pkg::qentry_t       head_o,
  output logic                    empty_o,
  output logic                    full_o
);
  import rtsf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  qentry_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == FullCnt;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rtsf_back.sv =====
// executor: closest pair average, rotation, held position and output register
// depends on rtsf_pkg
`default_nettype none

module rtsf_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  rtsf_pkg::rot_mode_e                rotation_i,
  input  rtsf_pkg::qentry_t                  head_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               touch_updated_o,
  output logic [rtsf_pkg::SampleW-1:0]       pos_x_o,
  output logic [rtsf_pkg::SampleW-1:0]       pos_y_o
);
  import rtsf_pkg::*;

  sample_t avg_x;
  sample_t avg_y;
  sample_t rot_x;
  sample_t rot_y;
  sample_t held_x_q, held_x_d;
  sample_t held_y_q, held_y_d;
  logic    out_valid_q, out_valid_d;
  logic    updated_q, updated_d;

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  assign avg_x = closest_avg(head_i.a0, head_i.a1, head_i.a2);
  assign avg_y = closest_avg(head_i.b0, head_i.b1, head_i.b2);

  always_comb begin
    unique case (rotation_i)
      RotSwapInvX: begin
        rot_x = FullScale - avg_y;
        rot_y = avg_x;
      end
      RotIdentity: begin
        rot_x = avg_x;
        rot_y = avg_y;
      end
      RotSwapInvY: begin
        rot_x = avg_y;
        rot_y = FullScale - avg_x;
      end
      default: begin
        rot_x = FullScale - avg_x;
        rot_y = FullScale - avg_y;
      end
    endcase
  end

  always_comb begin
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    updated_d   = updated_q;
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      updated_d   = head_i.good;
      if (head_i.good) begin
        held_x_d = rot_x;
        held_y_d = rot_y;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q    <= '0;
      held_y_q    <= '0;
      out_valid_q <= 1'b0;
      updated_q   <= 1'b0;
    end else begin
      held_x_q    <= held_x_d;
      held_y_q    <= held_y_d;
      out_valid_q <= out_valid_d;
      updated_q   <= updated_d;
    end
  end

  // held position is the output payload: it only moves when a new beat loads
  assign out_valid_o     = out_valid_q;
  assign touch_updated_o = updated_q;
  assign pos_x_o         = held_x_q;
  assign pos_y_o         = held_y_q;

`ifndef SYNTHESIS
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && head_i.good) |=> $stable(held_x_q) && $stable(held_y_q))
    else $error("held position changed without a good set");
  a_flag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> touch_updated_o == $past(head_i.good))
    else $error("update flag does not follow classification");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/resistive_touch_sample_filter.sv =====
// top level of the resistive touch sample filter: config registers and wiring
// depends on rtsf_pkg, rtsf_front, rtsf_queue, rtsf_back
`default_nettype none

// Filters touch-panel sample sets, one set per cycle while the queue has room.
// Every accepted beat gives exactly one result beat, in order: touch_updated_o is
// high when the set passed both the minimum-interval check (wrapping 32-bit
// microsecond time against the last good set) and the pressure check
// (pressure_one + 4095 - pressure_two against the threshold). On a good set
// the closest pair of each x and y triple is averaged, rotated by the
// rotation mode and held; pos_x_o/pos_y_o always show the held position.
// A result passes through the queue and then the output register. The single-cycle
// rate is set by the last-good-time register in the front end, which decides
// each set in the cycle it is accepted. A short queue separates the front
// end from the executor and output register, so input beats keep flowing
// while a finished result waits on out_stall_i; with the queue full the
// input is stalled. Configuration writes go through cfg_we_i/cfg_index_i and
// are meant for idle periods; index 3 is ignored.
module resistive_touch_sample_filter #(
  parameter int unsigned QueueDepth = rtsf_pkg::QueueDepthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [rtsf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [rtsf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [rtsf_pkg::TimeW-1:0]      now_us_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    pressure_one_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    pressure_two_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_a0_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_b0_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_a1_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_b1_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_a2_i,
  input  wire logic [rtsf_pkg::SampleW-1:0]    sample_b2_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 touch_updated_o,
  output logic [rtsf_pkg::SampleW-1:0]         pos_x_o,
  output logic [rtsf_pkg::SampleW-1:0]         pos_y_o
);
  import rtsf_pkg::*;

  // configuration registers
  rot_mode_e            rotation_q;
  logic [PressW-1:0]    threshold_q;
  logic [IntervalW-1:0] interval_q;

  // front end to queue
  logic    push;
  logic    q_full;
  qentry_t entry;

  // queue to executor
  logic    pop;
  logic    q_empty;
  qentry_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q  <= RotSwapInvX;
      threshold_q <= ResetThreshold;
      interval_q  <= ResetInterval;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRotation:  rotation_q  <= rot_mode_e'(cfg_wdata_i[1:0]);
        CfgThreshold: threshold_q <= cfg_wdata_i[PressW-1:0];
        CfgInterval:  interval_q  <= cfg_wdata_i[IntervalW-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // stall only on a full queue, never on the output side directly
  assign in_stall_o = q_full;

  rtsf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .now_us_i       (now_us_i),
    .pressure_one_i (pressure_one_i),
    .pressure_two_i (pressure_two_i),
    .sample_a0_i    (sample_a0_i),
    .sample_b0_i    (sample_b0_i),
    .sample_a1_i    (sample_a1_i),
    .sample_b1_i    (sample_b1_i),
    .sample_a2_i    (sample_a2_i),
    .sample_b2_i    (sample_b2_i),
    .threshold_i    (threshold_q),
    .interval_i     (interval_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (entry)
  );

  rtsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  rtsf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rotation_i      (rotation_q),
    .head_i          (head),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .touch_updated_o (touch_updated_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o)
  );

`ifndef SYNTHESIS
  a_accept_is_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) == push)
    else $error("input beat and queue push disagree");
`endif

endmodule

`default_nettype wire

// ===== test/rtsf_touch_checker.sv =====
// result checker of the resistive touch sample filter: predicts each result beat and compares it
// watches the config port and both channels; depends on rtsf_pkg only
`timescale 1ns / 100ps

module rtsf_touch_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rtsf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rtsf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_stall_i,
  input  wire logic [rtsf_pkg::TimeW-1:0]     now_us_i,
  input  wire rtsf_pkg::sample_t              pressure_one_i,
  input  wire rtsf_pkg::sample_t              pressure_two_i,
  input  wire rtsf_pkg::sample_t              sample_a0_i,
  input  wire rtsf_pkg::sample_t              sample_b0_i,
  input  wire rtsf_pkg::sample_t              sample_a1_i,
  input  wire rtsf_pkg::sample_t              sample_b1_i,
  input  wire rtsf_pkg::sample_t              sample_a2_i,
  input  wire rtsf_pkg::sample_t              sample_b2_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_stall_i,
  input  wire logic                           touch_updated_i,
  input  wire rtsf_pkg::sample_t              pos_x_i,
  input  wire rtsf_pkg::sample_t              pos_y_i,
  output int unsigned                         mismatch_count_o,
  output int unsigned                         owed_o
);
  import rtsf_pkg::*;

  typedef struct packed {
    logic    updated;
    sample_t x;
    sample_t y;
  } touch_result_t;

  touch_result_t        owed_q[$];
  int unsigned          fails;

  // filter state and register copies
  rot_mode_e            rot_mode;
  logic [PressW-1:0]    press_floor;
  logic [IntervalW-1:0] gap_floor;
  logic [TimeW-1:0]     last_good_us;
  sample_t              held_x;
  sample_t              held_y;

  // mean of the two nearest readings; ties prefer first+second, then first+third
  function automatic sample_t mean_of_closest(sample_t p, sample_t q, sample_t r);
    int d_pq;
    int d_pr;
    int d_qr;
    d_pq = int'(p) - int'(q);
    d_pr = int'(p) - int'(r);
    d_qr = int'(q) - int'(r);
    if (d_pq < 0) d_pq = -d_pq;
    if (d_pr < 0) d_pr = -d_pr;
    if (d_qr < 0) d_qr = -d_qr;
    if (d_pq <= d_pr && d_pq <= d_qr) return sample_t'((int'(p) + int'(q)) / 2);
    if (d_pr <= d_qr) return sample_t'((int'(p) + int'(r)) / 2);
    return sample_t'((int'(q) + int'(r)) / 2);
  endfunction

  function automatic touch_result_t apply_set(input logic [TimeW-1:0] now,
                                              input sample_t z1, z2,
                                              input sample_t a0, a1, a2,
                                              input sample_t b0, b1, b2);
    touch_result_t    res;
    logic [TimeW-1:0] elapsed;
    int               pressure;
    sample_t          xm;
    sample_t          ym;
    res.updated = 1'b0;
    elapsed = now - last_good_us;
    if (elapsed >= TimeW'(gap_floor)) begin
      pressure = int'(z1) + int'(FullScale) - int'(z2);
      if (pressure < 0) pressure = 0;
      if (pressure >= int'(press_floor)) begin
        xm = mean_of_closest(a0, a1, a2);
        ym = mean_of_closest(b0, b1, b2);
        case (rot_mode)
          RotSwapInvX: begin
            held_x = FullScale - ym;
            held_y = xm;
          end
          RotIdentity: begin
            held_x = xm;
            held_y = ym;
          end
          RotSwapInvY: begin
            held_x = ym;
            held_y = FullScale - xm;
          end
          default: begin
            held_x = FullScale - xm;
            held_y = FullScale - ym;
          end
        endcase
        last_good_us = now;
        res.updated = 1'b1;
      end
    end
    res.x = held_x;
    res.y = held_y;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    touch_result_t want;
    if (!rst_ni) begin
      rot_mode     = RotSwapInvX;
      press_floor  = ResetThreshold;
      gap_floor    = ResetInterval;
      last_good_us = '0;
      held_x       = '0;
      held_y       = '0;
      fails        = 0;
      owed_q.delete();
      mismatch_count_o <= 0;
      owed_o           <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgRotation:  rot_mode = rot_mode_e'(cfg_wdata_i[1:0]);
          CfgThreshold: press_floor = cfg_wdata_i[PressW-1:0];
          CfgInterval:  gap_floor = cfg_wdata_i[IntervalW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        owed_q.push_back(apply_set(now_us_i, pressure_one_i, pressure_two_i,
                                   sample_a0_i, sample_a1_i, sample_a2_i,
                                   sample_b0_i, sample_b1_i, sample_b2_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          $error("result beat with no sample set waiting for it");
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (touch_updated_i !== want.updated) begin
            $error("touch_updated: expected %0d, actual %0d", want.updated, touch_updated_i);
            fails++;
          end
          if (pos_x_i !== want.x) begin
            $error("pos_x: expected %0d, actual %0d", want.x, pos_x_i);
            fails++;
          end
          if (pos_y_i !== want.y) begin
            $error("pos_y: expected %0d, actual %0d", want.y, pos_y_i);
            fails++;
          end
        end
      end
      mismatch_count_o <= fails;
      owed_o           <= owed_q.size();
    end
  end

endmodule

// ===== test/tb_resistive_touch_sample_filter.sv =====
// testbench top of the resistive touch sample filter: clock, reset, stimulus and verdict
// depends on rtsf_pkg, resistive_touch_sample_filter and rtsf_touch_checker
`timescale 1ns / 100ps

module tb_resistive_touch_sample_filter;
  import rtsf_pkg::*;

  // index 3 has no register behind it, writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  // longest correct quiet spell is the receiver hold-off (HoldCycles) plus the config
  // writes; QuietLimit lies far beyond that, so reaching it is clearly a hang
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned HoldCycles = 100;
  localparam int unsigned PhaseCount = 7;
  localparam int unsigned PhaseItems = 150;

  typedef struct packed {
    logic [TimeW-1:0] now;
    sample_t          z1;
    sample_t          z2;
    sample_t          a0;
    sample_t          a1;
    sample_t          a2;
    sample_t          b0;
    sample_t          b1;
    sample_t          b2;
  } sample_set_t;

  typedef struct packed {
    sample_t s0;
    sample_t s1;
    sample_t s2;
  } triple_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = CfgRotation;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TimeW-1:0]     now_us = '0;
  sample_t              pressure_one = '0;
  sample_t              pressure_two = '0;
  sample_t              sample_a0 = '0;
  sample_t              sample_b0 = '0;
  sample_t              sample_a1 = '0;
  sample_t              sample_b1 = '0;
  sample_t              sample_a2 = '0;
  sample_t              sample_b2 = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 touch_updated;
  sample_t              pos_x;
  sample_t              pos_y;

  int unsigned          mismatches;
  int unsigned          results_owed;

  // handshake between stimulus and the receiver process
  bit                   calm = 1'b0;   // no idling on either side while set
  int unsigned          hold_asks = 0; // each increment asks for one long hold-off

  always #6 clk = ~clk;

  resistive_touch_sample_filter i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .now_us_i        (now_us),
    .pressure_one_i  (pressure_one),
    .pressure_two_i  (pressure_two),
    .sample_a0_i     (sample_a0),
    .sample_b0_i     (sample_b0),
    .sample_a1_i     (sample_a1),
    .sample_b1_i     (sample_b1),
    .sample_a2_i     (sample_a2),
    .sample_b2_i     (sample_b2),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .touch_updated_o (touch_updated),
    .pos_x_o         (pos_x),
    .pos_y_o         (pos_y)
  );

  rtsf_touch_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .now_us_i         (now_us),
    .pressure_one_i   (pressure_one),
    .pressure_two_i   (pressure_two),
    .sample_a0_i      (sample_a0),
    .sample_b0_i      (sample_b0),
    .sample_a1_i      (sample_a1),
    .sample_b1_i      (sample_b1),
    .sample_a2_i      (sample_a2),
    .sample_b2_i      (sample_b2),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .touch_updated_i  (touch_updated),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .mismatch_count_o (mismatches),
    .owed_o           (results_owed)
  );

  function automatic sample_set_t set_of(input logic [TimeW-1:0] now,
                                         input int z1, z2, a0, a1, a2, b0, b1, b2);
    sample_set_t s;
    s.now = now;
    s.z1  = sample_t'(z1);
    s.z2  = sample_t'(z2);
    s.a0  = sample_t'(a0);
    s.a1  = sample_t'(a1);
    s.a2  = sample_t'(a2);
    s.b0  = sample_t'(b0);
    s.b1  = sample_t'(b1);
    s.b2  = sample_t'(b2);
    return s;
  endfunction

  // one coordinate triple: noise, evenly spaced (tie cases) or a close pair plus an outlier
  function automatic triple_t make_triple();
    triple_t tr;
    int      v [3];
    int      base;
    int      d;
    int      k;
    int      pick;
    sample_t tmp;
    pick = $urandom_range(9);
    if (pick < 2) begin
      v[0] = $urandom_range(4095);
      v[1] = $urandom_range(4095);
      v[2] = $urandom_range(4095);
    end else if (pick < 4) begin
      d    = $urandom_range(600);
      base = $urandom_range(4095 - d, d);
      v[0] = base;
      v[1] = base + d;
      v[2] = base - d;
    end else begin
      base = $urandom_range(4095);
      v[0] = base;
      v[1] = base + int'($urandom_range(24)) - 12;
      if (v[1] < 0) v[1] = 0;
      if (v[1] > 4095) v[1] = 4095;
      v[2] = $urandom_range(4095);
    end
    k = $urandom_range(2);
    tr.s0 = sample_t'(v[k]);
    tr.s1 = sample_t'(v[(k + 1) % 3]);
    tr.s2 = sample_t'(v[(k + 2) % 3]);
    if ($urandom_range(1) == 1) begin
      tmp   = tr.s1;
      tr.s1 = tr.s2;
      tr.s2 = tmp;
    end
    return tr;
  endfunction

  // pressure mostly aimed at, around or above the threshold so plenty of sets pass
  function automatic sample_set_t make_random_set(input logic [TimeW-1:0] now,
                                                  input int unsigned thr);
    sample_set_t s;
    triple_t     xs;
    triple_t     ys;
    int          p;
    int          lo;
    int          hi;
    int          z1;
    int          pick;
    s.now = now;
    pick  = $urandom_range(9);
    if (pick < 3) begin
      s.z1 = sample_t'($urandom_range(4095));
      s.z2 = sample_t'($urandom_range(4095));
    end else begin
      if (pick < 6) p = int'(thr) + int'($urandom_range(4)) - 2;
      else p = $urandom_range(8190, thr);
      if (p < 0) p = 0;
      if (p > 8190) p = 8190;
      lo   = (p > 4095) ? p - 4095 : 0;
      hi   = (p < 4095) ? p : 4095;
      z1   = $urandom_range(hi, lo);
      s.z1 = sample_t'(z1);
      s.z2 = sample_t'(z1 + 4095 - p);
    end
    xs   = make_triple();
    ys   = make_triple();
    s.a0 = xs.s0;
    s.a1 = xs.s1;
    s.a2 = xs.s2;
    s.b0 = ys.s0;
    s.b1 = ys.s1;
    s.b2 = ys.s2;
    return s;
  endfunction

  // present one beat and hold it until taken, then maybe leave a gap
  task automatic offer_set(input sample_set_t s);
    in_valid     <= 1'b1;
    now_us       <= s.now;
    pressure_one <= s.z1;
    pressure_two <= s.z2;
    sample_a0    <= s.a0;
    sample_a1    <= s.a1;
    sample_a2    <= s.a2;
    sample_b0    <= s.b0;
    sample_b1    <= s.b1;
    sample_b2    <= s.b2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
  endtask

  // sender goes quiet until the last owed result beat is out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // writes all registers back to back; spare bits above rotation and threshold carry junk
  task automatic load_config(input rot_mode_e rot, input int unsigned thr,
                             input int unsigned gap);
    logic [31:0] junk;
    junk = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= CfgRotation;
    cfg_wdata <= {junk[15:2], rot};
    @(posedge clk);
    cfg_index <= CfgThreshold;
    cfg_wdata <= {junk[18:16], thr[12:0]};
    @(posedge clk);
    cfg_index <= CfgInterval;
    cfg_wdata <= gap[15:0];
    @(posedge clk);
    cfg_index <= CfgSpare;
    cfg_wdata <= junk[31:16];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, a quiet stretch while calm is set, and long hold-offs on request
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    logic        stall_next;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_seen != hold_asks) begin
        hold_seen++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else begin
        stall_next = !calm && ($urandom_range(99) < 16);
      end
      out_stall <= stall_next;
    end
  end

  // hang detection: cycles in a row with no beat on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    rot_mode_e        rot;
    int unsigned      thr;
    int unsigned      gap;
    int unsigned      pick;
    logic [TimeW-1:0] t;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: swap with x inverted, threshold 400, interval 3000
    // right after reset a set earlier than the interval is ignored
    offer_set(set_of(0, 4095, 0, 4095, 4095, 4095, 4095, 4095, 4095));
    offer_set(set_of(2999, 4095, 0, 4095, 4095, 4095, 4095, 4095, 4095));
    // pressure one below and exactly at the threshold
    offer_set(set_of(3000, 0, 3696, 1, 2, 3, 4, 5, 6));
    offer_set(set_of(3000, 0, 3695, 0, 1, 4095, 4095, 4094, 0));
    // first pair ties second pair; second pair ties third pair
    offer_set(set_of(6000, 4095, 0, 100, 110, 90, 100, 300, 200));
    offer_set(set_of(6001, 4095, 0, 5, 6, 7, 8, 9, 10));
    // elapsed time across the 32-bit wrap
    offer_set(set_of(32'hFFFF_FC00, 4095, 0, 0, 2000, 2010, 4095, 4095, 4095));
    offer_set(set_of(1000, 4095, 0, 11, 12, 13, 14, 15, 16));
    offer_set(set_of(1976, 0, 4095, 11, 12, 13, 14, 15, 16));
    offer_set(set_of(1976, 4095, 0, 7, 8, 9, 4095, 0, 2048));

    wait_for_drain();
    load_config(RotIdentity, 0, 0);
    offer_set(set_of(5, 0, 4095, 4095, 4095, 4095, 0, 0, 0));
    offer_set(set_of(5, 1234, 77, 1234, 1234, 1234, 2047, 2048, 2049));

    wait_for_drain();
    load_config(RotSwapInvY, 8190, 0);
    offer_set(set_of(50, 4094, 0, 300, 301, 302, 303, 304, 305));
    offer_set(set_of(100, 4095, 0, 0, 0, 0, 4095, 0, 4095));

    wait_for_drain();
    load_config(RotInvBoth, 1, 65535);
    offer_set(set_of(65635, 0, 4095, 1, 2, 3, 4, 5, 6));
    offer_set(set_of(65634, 1, 4095, 1, 2, 3, 4, 5, 6));
    offer_set(set_of(65635, 1, 4095, 10, 20, 30, 4095, 4095, 4094));
    offer_set(set_of(131169, 4095, 0, 1, 2, 3, 4, 5, 6));

    // random phases, each with its own register settings
    t = 32'd200000;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_for_drain();
      rot = rot_mode_e'(ph % 4);
      if (ph == 0) thr = 400;
      else if (ph == 2) thr = 0;
      else if (ph == 5) thr = 8190;
      else thr = $urandom_range(8190);
      if (ph == 0) gap = 3000;
      else if (ph == 3) gap = 0;
      else if (ph == 4) gap = 65535;
      else gap = $urandom_range(5000);
      load_config(rot, thr, gap);
      calm = (ph == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 1 && n == 30) hold_asks++;
        pick = $urandom_range(19);
        if (pick == 0) t = $urandom();
        else if (pick < 5) t = t + $urandom_range(gap);
        else if (pick < 7) t = t + gap;
        else t = t + gap + $urandom_range(300);
        offer_set(make_random_set(t, thr));
      end
    end
    calm = 1'b0;

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rtsf_pkg.sv
hw/rtl/rtsf_front.sv
hw/rtl/rtsf_queue.sv
hw/rtl/rtsf_back.sv
hw/rtl/resistive_touch_sample_filter.sv
test/rtsf_touch_checker.sv
test/tb_resistive_touch_sample_filter.sv
